// File: design/etwm_pkg.sv
// shared constants and types for the euler trs world matrix pipeline
package etwm_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int PHASE_BITS   = 24;
  localparam int STEPS        = 20;
  localparam int XW           = 34;
  localparam int ZW           = 25;
  localparam int CW           = 19;
  localparam int RW           = 58;
  localparam int PW           = 38;
  localparam int CORDIC_LAT   = STEPS + 2;
  localparam int POST_LAT     = 5;
  localparam int TOTAL_LAT    = CORDIC_LAT + POST_LAT;

  localparam logic signed [XW-1:0] GAIN = XW'(652032874);

  localparam logic signed [ZW-1:0] ATAN [STEPS] = '{
    ZW'(2097152), ZW'(1238021), ZW'(654136), ZW'(332050), ZW'(166669),
    ZW'(83416), ZW'(41718), ZW'(20860), ZW'(10430), ZW'(5215),
    ZW'(2608), ZW'(1304), ZW'(652), ZW'(326), ZW'(163),
    ZW'(81), ZW'(41), ZW'(20), ZW'(10), ZW'(5)
  };

  // position and scale carried alongside the angle work
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [23:0] scale_x;
    logic signed [23:0] scale_y;
    logic signed [23:0] scale_z;
  } side_t;

endpackage

// File: design/etwm_cordic.sv
// pipelined cordic giving Q2.16 cosine and sine of one binary angle
module etwm_cordic (
  input  logic                            clk,
  input  logic                            en,
  input  logic [15:0]                     angle,
  output logic signed [etwm_pkg::CW-1:0]  cos_o,
  output logic signed [etwm_pkg::CW-1:0]  sin_o
);

  localparam int XW = etwm_pkg::XW;
  localparam int ZW = etwm_pkg::ZW;
  localparam int CW = etwm_pkg::CW;
  localparam int N  = etwm_pkg::STEPS;
  localparam int RB = etwm_pkg::PHASE_BITS - 2;

  logic signed [XW-1:0] x_r [N+1];
  logic signed [XW-1:0] y_r [N+1];
  logic signed [ZW-1:0] z_r [N+1];
  logic [1:0]           q_r [N+1];
  logic [etwm_pkg::PHASE_BITS-1:0] ph;
  logic signed [XW-1:0] c_w, s_w;
  logic signed [CW-1:0] c_nxt, s_nxt;

  // phase from the low angle bits
  assign ph = etwm_pkg::PHASE_BITS'(angle[etwm_pkg::ANGLE_BITS-1:0])
              << (etwm_pkg::PHASE_BITS - etwm_pkg::ANGLE_BITS);

  // load stage, then one micro-rotation per stage
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= etwm_pkg::GAIN;
      y_r[0] <= '0;
      z_r[0] <= ZW'(ph[RB-1:0]);
      q_r[0] <= ph[etwm_pkg::PHASE_BITS-1:RB];
      for (int i = 0; i < N; i++) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - etwm_pkg::ATAN[i];
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + etwm_pkg::ATAN[i];
        end
      end
    end
  end

  // round to Q2.16 and map the quadrant
  always_comb begin
    c_w = (x_r[N] + XW'(8192)) >>> 14;
    s_w = (y_r[N] + XW'(8192)) >>> 14;
    unique case (q_r[N])
      2'd0: begin c_nxt = c_w[CW-1:0];    s_nxt = s_w[CW-1:0];    end
      2'd1: begin c_nxt = -s_w[CW-1:0];   s_nxt = c_w[CW-1:0];    end
      2'd2: begin c_nxt = -c_w[CW-1:0];   s_nxt = -s_w[CW-1:0];   end
      default: begin c_nxt = s_w[CW-1:0]; s_nxt = -c_w[CW-1:0];   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= c_nxt;
      sin_o <= s_nxt;
    end
  end

endmodule

// File: design/euler_trs_world_matrix.sv
// top level: streaming trs world matrix from position, scale and zyx euler angles
// Each item's angles pass through three parallel cordic pipelines (a load stage,
// 20 micro-rotation stages and an output register) for the sines and cosines,
// then five stages for the angle products, the three-factor products, rounding
// to Q.24, the scale multiply, and rounding with saturation into the output
// register. The whole pipeline holds while a result waits under out_stall, so
// in_stall follows out_stall whenever a result is pending; otherwise an item is
// taken every cycle. Translation is the position passed through unchanged.
module euler_trs_world_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [23:0] in_scale_x,
  input  logic signed [23:0] in_scale_y,
  input  logic signed [23:0] in_scale_z,
  input  logic [15:0]        in_angle_x,
  input  logic [15:0]        in_angle_y,
  input  logic [15:0]        in_angle_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_m00,
  output logic signed [23:0] out_m01,
  output logic signed [23:0] out_m02,
  output logic signed [23:0] out_m10,
  output logic signed [23:0] out_m11,
  output logic signed [23:0] out_m12,
  output logic signed [23:0] out_m20,
  output logic signed [23:0] out_m21,
  output logic signed [23:0] out_m22,
  output logic signed [31:0] out_trans_x,
  output logic signed [31:0] out_trans_y,
  output logic signed [31:0] out_trans_z
);

  localparam int CW  = etwm_pkg::CW;
  localparam int PW  = etwm_pkg::PW;
  localparam int RW  = etwm_pkg::RW;
  localparam int QW  = RW - 24;
  localparam int CL  = etwm_pkg::CORDIC_LAT;
  localparam int TL  = etwm_pkg::TOTAL_LAT;

  logic en;
  logic [TL-1:0] v_r;
  logic [TL-1:0] v_nxt;
  etwm_pkg::side_t side_r [TL];

  logic signed [CW-1:0] cx, sx, cy, sy, cz, sz;

  // stage a registers
  logic signed [PW-1:0] a_czcy_r, a_szcx_r, a_szsx_r, a_szcy_r, a_czcx_r;
  logic signed [PW-1:0] a_czsx_r, a_cysx_r, a_cycx_r, a_czsy_r, a_szsy_r;
  logic signed [CW-1:0] a_sx_r, a_cx_r, a_sy_r;
  // stage b, c, d and e registers
  logic signed [RW-1:0] b_r [9];
  logic signed [RW-1:0] b_nxt [9];
  logic signed [QW-1:0] c_r [9];
  logic signed [QW-1:0] c_nxt [9];
  logic signed [RW-1:0] d_r [9];
  logic signed [RW-1:0] d_nxt [9];
  logic signed [23:0]   e_r [9];
  logic signed [23:0]   e_nxt [9];

  // whole pipeline advances unless a result is held
  assign en       = !(v_r[TL-1] && out_stall);
  assign in_stall = !en;

  etwm_cordic u_cordic_x (.clk(clk), .en(en), .angle(in_angle_x), .cos_o(cx), .sin_o(sx));
  etwm_cordic u_cordic_y (.clk(clk), .en(en), .angle(in_angle_y), .cos_o(cy), .sin_o(sy));
  etwm_cordic u_cordic_z (.clk(clk), .en(en), .angle(in_angle_z), .cos_o(cz), .sin_o(sz));

  // valid bits travel with the data
  assign v_nxt = {v_r[TL-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  // position and scale delay line
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= '{pos_x: in_pos_x, pos_y: in_pos_y, pos_z: in_pos_z,
                     scale_x: in_scale_x, scale_y: in_scale_y, scale_z: in_scale_z};
      for (int i = 1; i < TL; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // stage a: two-factor products
  always_ff @(posedge clk) begin
    if (en) begin
      a_czcy_r <= PW'(cz) * PW'(cy);
      a_szcx_r <= PW'(sz) * PW'(cx);
      a_szsx_r <= PW'(sz) * PW'(sx);
      a_szcy_r <= PW'(sz) * PW'(cy);
      a_czcx_r <= PW'(cz) * PW'(cx);
      a_czsx_r <= PW'(cz) * PW'(sx);
      a_cysx_r <= PW'(cy) * PW'(sx);
      a_cycx_r <= PW'(cy) * PW'(cx);
      a_czsy_r <= PW'(cz) * PW'(sy);
      a_szsy_r <= PW'(sz) * PW'(sy);
      a_sx_r   <= sx;
      a_cx_r   <= cx;
      a_sy_r   <= sy;
    end
  end

  // stage b: exact Q.48 rotation entries
  always_comb begin
    b_nxt[0] = RW'(a_czcy_r) <<< 16;
    b_nxt[1] = RW'(a_czsy_r) * RW'(a_sx_r) - (RW'(a_szcx_r) <<< 16);
    b_nxt[2] = RW'(a_czsy_r) * RW'(a_cx_r) + (RW'(a_szsx_r) <<< 16);
    b_nxt[3] = RW'(a_szcy_r) <<< 16;
    b_nxt[4] = RW'(a_szsy_r) * RW'(a_sx_r) + (RW'(a_czcx_r) <<< 16);
    b_nxt[5] = RW'(a_szsy_r) * RW'(a_cx_r) - (RW'(a_czsx_r) <<< 16);
    b_nxt[6] = -(RW'(a_sy_r) <<< 32);
    b_nxt[7] = RW'(a_cysx_r) <<< 16;
    b_nxt[8] = RW'(a_cycx_r) <<< 16;
  end

  // stage c: round entries to Q.24
  always_comb begin
    logic signed [RW-1:0] t;
    for (int j = 0; j < 9; j++) begin
      t = (b_r[j] + (RW'(1) <<< 23)) >>> 24;
      c_nxt[j] = t[QW-1:0];
    end
  end

  // stage d: multiply by column scale
  always_comb begin
    etwm_pkg::side_t s;
    logic signed [23:0] k;
    s = side_r[CL+2];
    for (int j = 0; j < 9; j++) begin
      k = (j % 3 == 0) ? s.scale_x : ((j % 3 == 1) ? s.scale_y : s.scale_z);
      d_nxt[j] = RW'(c_r[j]) * RW'(k);
    end
  end

  // stage e: round to Q8.16 and saturate
  always_comb begin
    logic signed [RW-1:0] p;
    for (int j = 0; j < 9; j++) begin
      p = (d_r[j] + (RW'(1) <<< 23)) >>> 24;
      priority if (p > RW'(8388607)) begin
        e_nxt[j] = 24'sh7FFFFF;
      end else if (p < -RW'(8388608)) begin
        e_nxt[j] = -24'sh800000;
      end else begin
        e_nxt[j] = p[23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 9; j++) begin
        b_r[j] <= b_nxt[j];
        c_r[j] <= c_nxt[j];
        d_r[j] <= d_nxt[j];
        e_r[j] <= e_nxt[j];
      end
    end
  end

  // outputs
  assign out_valid   = v_r[TL-1];
  assign out_m00     = e_r[0];
  assign out_m01     = e_r[1];
  assign out_m02     = e_r[2];
  assign out_m10     = e_r[3];
  assign out_m11     = e_r[4];
  assign out_m12     = e_r[5];
  assign out_m20     = e_r[6];
  assign out_m21     = e_r[7];
  assign out_m22     = e_r[8];
  assign out_trans_x = side_r[TL-1].pos_x;
  assign out_trans_y = side_r[TL-1].pos_y;
  assign out_trans_z = side_r[TL-1].pos_z;

endmodule

// File: dv/euler_trs_world_matrix_checker.sv
// checker: predicts the world matrix of each accepted item and compares results
module euler_trs_world_matrix_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [23:0] in_scale_x,
  input  logic signed [23:0] in_scale_y,
  input  logic signed [23:0] in_scale_z,
  input  logic [15:0]        in_angle_x,
  input  logic [15:0]        in_angle_y,
  input  logic [15:0]        in_angle_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [23:0] out_m00,
  input  logic signed [23:0] out_m01,
  input  logic signed [23:0] out_m02,
  input  logic signed [23:0] out_m10,
  input  logic signed [23:0] out_m11,
  input  logic signed [23:0] out_m12,
  input  logic signed [23:0] out_m20,
  input  logic signed [23:0] out_m21,
  input  logic signed [23:0] out_m22,
  input  logic signed [31:0] out_trans_x,
  input  logic signed [31:0] out_trans_y,
  input  logic signed [31:0] out_trans_z,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [23:0] m [9];
    logic signed [31:0] t [3];
  } matrix_t;

  matrix_t expected_matrices[$];

  localparam longint ATAN_TURN [20] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  // floor shift on a signed 64-bit value
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // cordic sine and cosine in Q2.16 of a binary angle
  function automatic void angle_sin_cos(input logic [15:0] ang, output longint c,
                                        output longint s);
    logic [23:0] ph;
    logic [1:0] quad;
    longint z, x, y, dx, dy, cr, sr;
    ph = {ang[etwm_pkg::ANGLE_BITS-1:0], 8'd0};
    quad = ph[23:22];
    z = longint'(ph[21:0]);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 20; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURN[i];
      end
    end
    cr = floor_shr(x + 8192, 14);
    sr = floor_shr(y + 8192, 14);
    case (quad)
      2'd0: begin c = cr;  s = sr;  end
      2'd1: begin c = -sr; s = cr;  end
      2'd2: begin c = -cr; s = -sr; end
      default: begin c = sr; s = -cr; end
    endcase
  endfunction

  // round the Q.48 entry, apply scale, round and saturate to Q8.16
  function automatic logic signed [23:0] scaled_entry(longint r48, longint k);
    longint r24, p;
    r24 = floor_shr(r48 + (64'sd1 << 23), 24);
    p = floor_shr(r24 * k + (64'sd1 << 23), 24);
    if (p > 8388607) p = 8388607;
    if (p < -8388608) p = -8388608;
    return p[23:0];
  endfunction

  function automatic matrix_t world_matrix();
    matrix_t w;
    longint cx, sx, cy, sy, cz, sz, czsy, szsy;
    longint r [9];
    longint k [3];
    angle_sin_cos(in_angle_x, cx, sx);
    angle_sin_cos(in_angle_y, cy, sy);
    angle_sin_cos(in_angle_z, cz, sz);
    k[0] = in_scale_x; k[1] = in_scale_y; k[2] = in_scale_z;
    czsy = cz * sy;
    szsy = sz * sy;
    r[0] = cz * cy * 65536;
    r[1] = czsy * sx - sz * cx * 65536;
    r[2] = czsy * cx + sz * sx * 65536;
    r[3] = sz * cy * 65536;
    r[4] = szsy * sx + cz * cx * 65536;
    r[5] = szsy * cx - cz * sx * 65536;
    r[6] = -sy * 64'sd4294967296;
    r[7] = cy * sx * 65536;
    r[8] = cy * cx * 65536;
    for (int j = 0; j < 9; j++) w.m[j] = scaled_entry(r[j], k[j % 3]);
    w.t[0] = in_pos_x; w.t[1] = in_pos_y; w.t[2] = in_pos_z;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // predict on input handshake, compare on output handshake
  always @(posedge clk) begin
    matrix_t want, got;
    if (!rst_n) begin
      fail_count = 0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) expected_matrices.push_back(world_matrix());
      if (out_valid && !out_stall) begin
        got.m = '{out_m00, out_m01, out_m02, out_m10, out_m11, out_m12,
                  out_m20, out_m21, out_m22};
        got.t = '{out_trans_x, out_trans_y, out_trans_z};
        if (expected_matrices.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          want = expected_matrices.pop_front();
          for (int j = 0; j < 9; j++)
            if (got.m[j] !== want.m[j])
              report_mismatch($sformatf("m%0d%0d", j / 3, j % 3), got.m[j], want.m[j]);
          for (int j = 0; j < 3; j++)
            if (got.t[j] !== want.t[j])
              report_mismatch($sformatf("trans%0d", j), got.t[j], want.t[j]);
        end
      end
      pending <= expected_matrices.size();
    end
  end
endmodule

// File: dv/euler_trs_world_matrix_test.sv
// testbench top: stimulus, receiver stalls, verdict for the world matrix block
module euler_trs_world_matrix_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [23:0] in_scale_x, in_scale_y, in_scale_z;
  logic [15:0] in_angle_x, in_angle_y, in_angle_z;
  logic signed [23:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  logic signed [23:0] out_m20, out_m21, out_m22;
  logic signed [31:0] out_trans_x, out_trans_y, out_trans_z;
  int fail_count, pending;
  bit hold_long;

  euler_trs_world_matrix dut (.*);
  euler_trs_world_matrix_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (80) @(posedge clk);
        out_stall <= 0;
        wait (!hold_long);
      end else begin
        mode = $urandom_range(0, 3);
        repeat ($urandom_range(1, 30)) begin
          case (mode)
            0: out_stall <= 0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'h010000;
      3: return 24'hff0000;
      4: return 24'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3)) << 14;
      1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 2)) - 16'd1;
      default: return $urandom;
    endcase
  endfunction

  // offer one item and hold it until accepted
  task automatic send_item(input logic [31:0] px, py, pz, input logic [23:0] kx, ky, kz,
                           input logic [15:0] ax, ay, az);
    in_valid <= 1;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    in_scale_x <= kx; in_scale_y <= ky; in_scale_z <= kz;
    in_angle_x <= ax; in_angle_y <= ay; in_angle_z <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random();
    send_item(pick_pos(), pick_pos(), pick_pos(), pick_scale(), pick_scale(), pick_scale(),
              pick_angle(), pick_angle(), pick_angle());
  endtask

  initial begin
    int sent, waited;
    hold_long = 0;
    rst_n = 0;
    in_valid = 0;
    {in_pos_x, in_pos_y, in_pos_z} = '0;
    {in_scale_x, in_scale_y, in_scale_z} = '0;
    {in_angle_x, in_angle_y, in_angle_z} = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: quadrants, extreme angles and scales, mirrored axes
    send_item(0, 0, 0, 24'h010000, 24'h010000, 24'h010000, 0, 0, 0);
    send_item(32'h7fffffff, 32'h80000000, 32'hffffffff, 24'h7fffff, 24'h7fffff, 24'h7fffff,
              16'h4000, 16'h8000, 16'hc000);
    send_item(32'h80000000, 32'h7fffffff, 1, 24'h800000, 24'h800000, 24'h800000,
              16'hffff, 16'hffff, 16'hffff);
    send_item(1, 2, 3, 24'hff0000, 24'h010000, 24'hff0000, 16'h2000, 16'h6000, 16'ha000);
    send_item(-5, 7, -9, 24'h000000, 24'hffffff, 24'h000001, 16'h0001, 16'h3fff, 16'h4001);
    send_item(32'h55555555, 32'haaaaaaaa, 0, 24'h555555, 24'haaaaaa, 24'h7fffff,
              16'h5555, 16'haaaa, 16'h8001);
    send_item(0, 0, 0, 24'h7fffff, 24'h800000, 24'h010000, 16'hc000, 16'h4000, 16'h8000);
    for (int q = 0; q < 4; q++)
      send_item(q, -q, q, 24'h020000, 24'hfe0000, 24'h008000,
                16'(q) << 14, 16'(3 - q) << 14, (16'(q) << 14) + 16'h1000);

    // long receiver hold-off while the sender keeps offering
    hold_long = 1;
    repeat (60) send_random();
    hold_long = 0;
    in_valid <= 0;

    // pause until every prediction has been matched
    wait (pending == 0);
    @(posedge clk);

    // random bursts with gaps
    sent = 0;
    while (sent < 1080) begin
      repeat ($urandom_range(1, 40)) begin
        send_random();
        sent++;
      end
      in_valid <= 0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge clk);
      else @(posedge clk);
    end
    in_valid <= 0;

    waited = 0;
    while ((pending != 0 || out_valid) && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (etwm_pkg::TOTAL_LAT + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0 && waited < 20000) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
